// ===== src/srw_pkg.sv =====
// shared types and constants for the selective-repeat sender window
// no dependencies; imported by selective_repeat_window and both testbench modules
package srw_pkg;

   localparam int WINDOW_MAX_DEF = 64;
   localparam int FRAME_BITS_DEF = 16;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int SEQ_W       = 3;
   localparam int TOTAL_W     = 16;
   localparam int FRAME_OUT_W = 16;
   localparam int SLOT_OUT_W  = 6;

   localparam logic [SEQ_W-1:0]   SEQ_BITS_RST     = 3'd3;
   localparam logic [TOTAL_W-1:0] TOTAL_FRAMES_RST = 16'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_BITS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_FRAMES = 2'd1;

   typedef enum logic [2:0] {
      ST_FETCH,
      ST_READY,
      ST_COMPACT,
      ST_FILL,
      ST_FINISHED
   } state_type;

endpackage

// ===== src/srw_frame_ram.sv =====
// frame number store: one write port, one read port with registered read data
// generic; no package dependency
module srw_frame_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/selective_repeat_window.sv =====
// selective-repeat sender window, frame numbers and send outcomes in srw_frame_ram
// response: mid window registered from the accepting edge, so rsp_tvalid follows in the next cycle;
//   at window end it waits for the rebuild (compaction, then one new frame per slot left free)
// each send passes a slot read (ST_FETCH), then the accept (ST_READY), which also waits while
//   a response is held by rsp_tready; window end adds the rebuild: compaction, new frames, close
// reset (synchronous) and writes to either config register restart the transfer at once;
//   the first window reads as slot numbers, so the store needs no clearing pass
module selective_repeat_window #(
   parameter int WINDOW_MAX = srw_pkg::WINDOW_MAX_DEF,
   parameter int FRAME_BITS = srw_pkg::FRAME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: received_ok
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [srw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // rsp_tdata: sent_frame, slot_index, resend_needed, resend_frame, all_done
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [srw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [srw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import srw_pkg::*;

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

   function automatic logic [CNT_W-1:0] win_size(input logic [SEQ_W-1:0] sb);
      logic [SEQ_W-1:0] b;
      logic [6:0]       w;
      b = (sb == '0) ? SEQ_W'(1) : sb;
      w = 7'd1 << (b - SEQ_W'(1));
      if (w > 7'(WINDOW_MAX)) begin
         w = 7'(WINDOW_MAX);
      end
      return CNT_W'(w);
   endfunction

   function automatic logic [CNT_W-1:0] min_count(input logic [CNT_W-1:0] w,
                                                  input logic [TOTAL_W-1:0] n);
      return (TOTAL_W'(w) < n) ? w : CNT_W'(n);
   endfunction

   state_type               state_ff, state_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]        window_count_ff, window_count_in;
   logic [SLOT_W-1:0]       current_slot_ff, current_slot_in;
   logic [FRAME_BITS-1:0]   next_new_ff, next_new_in;
   logic [TOTAL_W-1:0]      remaining_ff, remaining_in;
   logic                    fresh_ff, fresh_in;
   logic [CNT_W-1:0]        size_ff, size_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    pipe_vld_ff, pipe_vld_in;
   logic [SLOT_W-1:0]       pipe_idx_ff, pipe_idx_in;
   logic [CNT_W-1:0]        wr_idx_ff, wr_idx_in;
   logic                    err_ff, err_in;
   logic [FRAME_BITS-1:0]   first_err_ff, first_err_in;
   logic [FRAME_BITS-1:0]   hold_frame_ff, hold_frame_in;
   logic [SLOT_W-1:0]       hold_slot_ff, hold_slot_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FRAME_OUT_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [SLOT_OUT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_resend_ff, rsp_resend_in;
   logic [FRAME_OUT_W-1:0]  rsp_rframe_ff, rsp_rframe_in;
   logic                    rsp_done_ff, rsp_done_in;

   // store word: outcome bit above the frame number
   logic                    ram_wr_en;
   logic [SLOT_W-1:0]       ram_wr_addr;
   logic [FRAME_BITS:0]     ram_wr_data;
   logic [SLOT_W-1:0]       ram_rd_addr;
   logic [FRAME_BITS:0]     ram_rd_data;

   logic                    req_fire;

   srw_frame_ram #(
      .DEPTH  (WINDOW_MAX),
      .WIDTH  (FRAME_BITS + 1),
      .ADDR_W (SLOT_W)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_FINISHED) ||
                       ((state_ff == ST_READY) && (!rsp_valid_ff || rsp_tready));
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      logic                  restart;
      logic [SEQ_W-1:0]      cfg_seq;
      logic [TOTAL_W-1:0]    cfg_total;
      logic [CNT_W-1:0]      rs_count;
      logic                  ok;
      logic [FRAME_BITS-1:0] frame;
      logic [TOTAL_W-1:0]    rem_next;
      logic [CNT_W-1:0]      new_size;
      logic [FRAME_BITS-1:0] moved;

      state_in        = state_ff;
      seq_in          = seq_ff;
      total_in        = total_ff;
      window_count_in = window_count_ff;
      current_slot_in = current_slot_ff;
      next_new_in     = next_new_ff;
      remaining_in    = remaining_ff;
      fresh_in        = fresh_ff;
      size_in         = size_ff;
      cnt_in          = cnt_ff;
      pipe_vld_in     = 1'b0;
      pipe_idx_in     = pipe_idx_ff;
      wr_idx_in       = wr_idx_ff;
      err_in          = err_ff;
      first_err_in    = first_err_ff;
      hold_frame_in   = hold_frame_ff;
      hold_slot_in    = hold_slot_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_frame_in    = rsp_frame_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_resend_in   = rsp_resend_ff;
      rsp_rframe_in   = rsp_rframe_ff;
      rsp_done_in     = rsp_done_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = wr_idx_ff[SLOT_W-1:0];
      ram_wr_data     = {1'b0, next_new_ff};
      ram_rd_addr     = current_slot_ff;

      ok       = req_tdata[0];
      frame    = fresh_ff ? FRAME_BITS'(current_slot_ff) : ram_rd_data[FRAME_BITS-1:0];
      rem_next = (ok && (remaining_ff != '0)) ? remaining_ff - TOTAL_W'(1) : remaining_ff;
      new_size = min_count(win_size(seq_ff), rem_next);
      moved    = fresh_ff ? FRAME_BITS'(pipe_idx_ff) : ram_rd_data[FRAME_BITS-1:0];

      unique case (state_ff)
         ST_FETCH: begin
            state_in = ST_READY;
         end
         ST_READY: begin
            if (req_fire) begin
               // every slot of the window is sent before compaction reads it back
               ram_wr_en    = 1'b1;
               ram_wr_addr  = current_slot_ff;
               ram_wr_data  = {ok, frame};
               remaining_in = rem_next;
               if (CNT_W'(current_slot_ff) + CNT_W'(1) < window_count_ff) begin
                  current_slot_in = current_slot_ff + SLOT_W'(1);
                  rsp_valid_in    = 1'b1;
                  rsp_frame_in    = FRAME_OUT_W'(frame);
                  rsp_slot_in     = SLOT_OUT_W'(current_slot_ff);
                  rsp_last_in     = 1'b0;
                  rsp_resend_in   = 1'b0;
                  rsp_rframe_in   = '0;
                  rsp_done_in     = 1'b0;
                  state_in        = ST_FETCH;
               end else if (new_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_frame_in  = FRAME_OUT_W'(frame);
                  rsp_slot_in   = SLOT_OUT_W'(current_slot_ff);
                  rsp_last_in   = 1'b1;
                  rsp_resend_in = 1'b0;
                  rsp_rframe_in = '0;
                  rsp_done_in   = 1'b1;
                  state_in      = ST_FINISHED;
               end else begin
                  hold_frame_in = frame;
                  hold_slot_in  = current_slot_ff;
                  size_in       = new_size;
                  cnt_in        = '0;
                  wr_idx_in     = '0;
                  err_in        = 1'b0;
                  state_in      = ST_COMPACT;
               end
            end
         end
         ST_COMPACT: begin
            ram_rd_addr = cnt_ff[SLOT_W-1:0];
            if (cnt_ff < window_count_ff) begin
               pipe_vld_in = 1'b1;
               pipe_idx_in = cnt_ff[SLOT_W-1:0];
               cnt_in      = cnt_ff + CNT_W'(1);
            end
            // errored frames slide down to the lowest free slot
            if (pipe_vld_ff && !ram_rd_data[FRAME_BITS]) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {1'b0, moved};
               wr_idx_in   = wr_idx_ff + CNT_W'(1);
               err_in      = 1'b1;
               if (!err_ff) begin
                  first_err_in = moved;
               end
            end
            if ((cnt_ff == window_count_ff) && !pipe_vld_ff) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (wr_idx_ff < size_ff) begin
               ram_wr_en   = 1'b1;
               next_new_in = next_new_ff + FRAME_BITS'(1);
               wr_idx_in   = wr_idx_ff + CNT_W'(1);
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_frame_in    = FRAME_OUT_W'(hold_frame_ff);
               rsp_slot_in     = SLOT_OUT_W'(hold_slot_ff);
               rsp_last_in     = 1'b1;
               rsp_resend_in   = err_ff;
               rsp_rframe_in   = err_ff ? FRAME_OUT_W'(first_err_ff) : '0;
               rsp_done_in     = 1'b0;
               window_count_in = size_ff;
               current_slot_in = '0;
               fresh_in        = 1'b0;
               state_in        = ST_FETCH;
            end
         end
         ST_FINISHED: begin
            state_in = ST_FINISHED;
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase

      // reset and writes to the two configuration registers restart the transfer
      restart   = reset;
      cfg_seq   = seq_ff;
      cfg_total = total_ff;
      if (reset) begin
         cfg_seq   = SEQ_BITS_RST;
         cfg_total = TOTAL_FRAMES_RST;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SEQ_BITS) begin
            cfg_seq = csr_wdata[SEQ_W-1:0];
            restart = 1'b1;
         end else if (csr_index == CSR_TOTAL_FRAMES) begin
            cfg_total = csr_wdata[TOTAL_W-1:0];
            restart   = 1'b1;
         end
      end
      rs_count = min_count(win_size(cfg_seq), cfg_total);
      if (restart) begin
         seq_in          = cfg_seq;
         total_in        = cfg_total;
         window_count_in = rs_count;
         current_slot_in = '0;
         next_new_in     = FRAME_BITS'(rs_count);
         remaining_in    = cfg_total;
         fresh_in        = 1'b1;
         pipe_vld_in     = 1'b0;
         ram_wr_en       = 1'b0;
         state_in        = (rs_count == '0) ? ST_FINISHED : ST_FETCH;
      end
      if (reset) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      state_ff        <= state_in;
      seq_ff          <= seq_in;
      total_ff        <= total_in;
      window_count_ff <= window_count_in;
      current_slot_ff <= current_slot_in;
      next_new_ff     <= next_new_in;
      remaining_ff    <= remaining_in;
      fresh_ff        <= fresh_in;
      size_ff         <= size_in;
      cnt_ff          <= cnt_in;
      pipe_vld_ff     <= pipe_vld_in;
      pipe_idx_ff     <= pipe_idx_in;
      wr_idx_ff       <= wr_idx_in;
      err_ff          <= err_in;
      first_err_ff    <= first_err_in;
      hold_frame_ff   <= hold_frame_in;
      hold_slot_ff    <= hold_slot_in;
      rsp_valid_ff    <= rsp_valid_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_resend_ff   <= rsp_resend_in;
      rsp_rframe_ff   <= rsp_rframe_in;
      rsp_done_ff     <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_done_ff, rsp_rframe_ff, rsp_resend_ff, rsp_slot_ff, rsp_frame_ff};

`ifndef NO_ASSERTIONS
   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READY) |-> (CNT_W'(current_slot_ff) < window_count_ff))
      else $error("current slot outside the window");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (wr_idx_ff <= size_ff))
      else $error("rebuild wrote past the new window size");

   a_mid_window_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (!rsp_resend_ff && !rsp_done_ff))
      else $error("window-end flags on a mid-window transaction");

   a_send_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (state_ff == ST_READY) && !csr_wr_en &&
       (CNT_W'(current_slot_ff) + CNT_W'(1) < window_count_ff)) |=> rsp_valid_ff)
      else $error("accepted send produced no transaction");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FETCH) || (state_ff == ST_FINISHED)) |-> !ram_wr_en)
      else $error("frame store written while fetching or finished");
`endif

endmodule

// ===== tb/selective_repeat_window_checker.sv =====
`timescale 1ns / 100ps
// response checker for selective_repeat_window: follows csr writes and request
// transactions with its own window model and compares every response transaction
// depends on srw_pkg for widths and register indexes
module selective_repeat_window_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [srw_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [srw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            csr_wr_en,
   input  logic [srw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srw_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending,
   output logic                            xfer_done
);

   import srw_pkg::*;

   localparam int SLOTS = WINDOW_MAX_DEF;

   typedef struct {
      logic [FRAME_OUT_W-1:0] sent_frame;
      logic [SLOT_OUT_W-1:0]  slot;
      logic                   window_end;
      logic                   resend_needed;
      logic [FRAME_OUT_W-1:0] resend_frame;
      logic                   all_done;
   } send_report_type;

   send_report_type sends_due[$];

   logic [SEQ_W-1:0]       seq_bits_q;
   logic [TOTAL_W-1:0]     total_q;
   logic [FRAME_OUT_W-1:0] win_frames [SLOTS];
   bit                     slot_ok [SLOTS];
   int                     win_count;
   int                     cur_slot;
   int                     remaining;
   logic [FRAME_OUT_W-1:0] next_frame;
   bit                     finished;

   initial begin
      fail_count = 0;
      pending    = 0;
      xfer_done  = 1'b0;
   end

   function int window_size();
      int b;
      int w;
      b = (seq_bits_q == 0) ? 1 : int'(seq_bits_q);
      w = 1 << (b - 1);
      return (w > SLOTS) ? SLOTS : w;
   endfunction

   function void restart_transfer();
      int w;
      w = window_size();
      win_count = (w < int'(total_q)) ? w : int'(total_q);
      for (int i = 0; i < SLOTS; i++) begin
         win_frames[i] = (i < win_count) ? FRAME_OUT_W'(i) : '0;
         slot_ok[i]    = 1'b0;
      end
      cur_slot   = 0;
      next_frame = FRAME_OUT_W'(win_count);
      remaining  = int'(total_q);
      finished   = (win_count == 0);
   endfunction

   // one send outcome; returns 1 when a response transaction follows
   function bit take_outcome(input bit delivered, output send_report_type r);
      int  slot;
      int  w;
      int  size;
      int  idx;
      bit  any_err;
      r = '{default: '0};
      any_err = 1'b0;
      if (finished || win_count == 0)
         return 1'b0;
      slot = cur_slot % SLOTS;
      r.sent_frame = win_frames[slot];
      r.slot       = SLOT_OUT_W'(slot);
      slot_ok[slot] = delivered;
      if (delivered && remaining > 0)
         remaining--;
      if (slot + 1 < win_count) begin
         cur_slot = slot + 1;
         return 1'b1;
      end
      r.window_end = 1'b1;
      w = window_size();
      size = (w < remaining) ? w : remaining;
      if (size == 0) begin
         finished   = 1'b1;
         r.all_done = 1'b1;
         return 1'b1;
      end
      // failed frames move to the front in order, fresh numbers fill the rest
      idx = 0;
      for (int i = 0; i < win_count; i++) begin
         if (!slot_ok[i]) begin
            win_frames[idx] = win_frames[i];
            idx++;
            any_err = 1'b1;
         end
      end
      while (idx < size) begin
         win_frames[idx] = next_frame;
         next_frame++;
         idx++;
      end
      for (int i = 0; i < SLOTS; i++)
         slot_ok[i] = 1'b0;
      win_count = size;
      cur_slot  = 0;
      if (any_err) begin
         r.resend_needed = 1'b1;
         r.resend_frame  = win_frames[0];
      end
      return 1'b1;
   endfunction

   task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin : track
      send_report_type due;
      send_report_type seen;
      if (reset) begin
         seq_bits_q = SEQ_BITS_RST;
         total_q    = TOTAL_FRAMES_RST;
         restart_transfer();
         sends_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SEQ_BITS: begin
                  seq_bits_q = csr_wdata[SEQ_W-1:0];
                  restart_transfer();
               end
               CSR_TOTAL_FRAMES: begin
                  total_q = csr_wdata[TOTAL_W-1:0];
                  restart_transfer();
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (take_outcome(req_tdata[0], due))
               sends_due.push_back(due);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.sent_frame    = rsp_tdata[15:0];
            seen.slot          = rsp_tdata[21:16];
            seen.window_end    = rsp_tlast;
            seen.resend_needed = rsp_tdata[22];
            seen.resend_frame  = rsp_tdata[38:23];
            seen.all_done      = rsp_tdata[39];
            if (sends_due.size() == 0) begin
               report_mismatch($sformatf("response for frame %0d with no send pending",
                                         seen.sent_frame));
            end else begin
               due = sends_due.pop_front();
               check_field("sent_frame", 32'(seen.sent_frame), 32'(due.sent_frame));
               check_field("slot_index", 32'(seen.slot), 32'(due.slot));
               check_field("window_end", 32'(seen.window_end), 32'(due.window_end));
               check_field("resend_needed", 32'(seen.resend_needed),
                           32'(due.resend_needed));
               check_field("resend_frame", 32'(seen.resend_frame),
                           32'(due.resend_frame));
               check_field("all_done", 32'(seen.all_done), 32'(due.all_done));
            end
         end
      end
      pending   <= sends_due.size();
      xfer_done <= finished;
   end

endmodule

// ===== tb/selective_repeat_window_tb.sv =====
`timescale 1ns / 100ps
// top of the selective_repeat_window testbench: clock, reset, send outcomes
// and csr settings, bursty sender and stalling receiver, final verdict
// depends on srw_pkg, selective_repeat_window and selective_repeat_window_checker
module selective_repeat_window_tb;
   import srw_pkg::*;

   localparam int ITEM_TARGET   = 1250;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 200;

   // indexes past the register list
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int   fail_count;
   int   pending;
   logic xfer_done;

   int   cycle_cnt = 0;
   int   burst_left = 0;
   int   sends_made = 0;
   bit   hold_go = 1'b0;
   bit   hold_done = 1'b0;
   int   hold_left = 0;
   int   stall_mode = 0;
   int   mode_left = 0;
   logic [3:0] pattern_cnt = '0;

   selective_repeat_window dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   selective_repeat_window_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .xfer_done  (xfer_done)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: one long hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      pattern_cnt <= pattern_cnt + 1'b1;
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(16, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= pattern_cnt[1];
         endcase
      end
   end

   task send_outcome(input bit delivered);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (!xfer_done)
         sends_made++;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-1){1'b0}}, delivered};
      do @(posedge clock); while (!req_tready);
   endtask

   task stop_sending();
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   task wait_drained();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int round;
      int err_pct;
      int budget;
      int sent;
      logic [SEQ_W-1:0]   seq;
      logic [TOTAL_W-1:0] total;
      round = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings after reset: four-slot window over eight frames
      send_outcome(1'b0);
      send_outcome(1'b1);
      send_outcome(1'b1);
      send_outcome(1'b0);
      send_outcome(1'b1);
      send_outcome(1'b1);
      send_outcome(1'b1);
      send_outcome(1'b1);
      stop_sending();
      wait_drained();

      // zero sequence bits: single-slot window, resend, finish, then ignored
      csr_write(CSR_SEQ_BITS, '0);
      csr_write(CSR_TOTAL_FRAMES, 16'd2);
      send_outcome(1'b0);
      send_outcome(1'b1);
      send_outcome(1'b1);
      send_outcome(1'b1);
      stop_sending();
      wait_drained();

      // nothing to send at all
      csr_write(CSR_TOTAL_FRAMES, '0);
      send_outcome(1'b1);
      send_outcome(1'b0);
      stop_sending();
      wait_drained();

      // widest window, largest frame count, upper data bits set
      csr_write(CSR_SEQ_BITS, {13'h1fff, 3'd7});
      csr_write(CSR_TOTAL_FRAMES, 16'hffff);
      send_outcome(1'b1);
      send_outcome(1'b0);
      send_outcome(1'b1);
      send_outcome(1'b0);
      stop_sending();
      wait_drained();

      // writes past the register list leave the transfer alone
      csr_write(CSR_SPARE_A, CSR_DATA_W'($urandom));
      csr_write(CSR_SPARE_B, CSR_DATA_W'($urandom));
      send_outcome(1'b1);
      send_outcome(1'b0);
      stop_sending();
      wait_drained();

      sends_made = 0;
      while (sends_made < ITEM_TARGET) begin
         round++;
         seq = SEQ_W'($urandom_range(0, 7));
         case ($urandom_range(0, 11))
            0:       total = 16'd1;
            1, 2:    total = TOTAL_W'($urandom_range(41, 300));
            3:       total = 16'hffff;
            default: total = TOTAL_W'($urandom_range(1, 40));
         endcase
         case ($urandom_range(0, 5))
            0:       err_pct = 0;
            1:       err_pct = 5;
            2:       err_pct = 20;
            3:       err_pct = 50;
            4:       err_pct = 90;
            default: err_pct = 100;
         endcase
         if (round == 3) begin
            total   = 16'd200;
            err_pct = 20;
            hold_go <= 1'b1;
         end
         csr_write(CSR_SEQ_BITS, {13'($urandom), seq});
         csr_write(CSR_TOTAL_FRAMES, total);
         budget = $urandom_range(60, 200);
         sent = 0;
         while (!xfer_done && sent < budget) begin
            send_outcome($urandom_range(0, 99) >= err_pct);
            sent++;
         end
         repeat ($urandom_range(0, 2)) send_outcome(1'($urandom_range(0, 1)));
         stop_sending();
         wait_drained();
      end

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== selective_repeat_window.f =====
src/srw_pkg.sv
src/srw_frame_ram.sv
src/selective_repeat_window.sv
tb/selective_repeat_window_checker.sv
tb/selective_repeat_window_tb.sv
